// ----- src/rm_pkg.sv -----
// ----------------------------------------------------------------------------
// rm_pkg: running median shared definitions
// Field widths, parameter defaults, payload types and controller states.
// ----------------------------------------------------------------------------
package rm_pkg;

  localparam int SAMPLE_W           = 20;
  localparam int HELD_W             = 11;
  localparam int CAPACITY_DEFAULT   = 1024;
  localparam int VALUE_BITS_DEFAULT = 20;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                start_new;
  } rm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] median_value;
    logic [HELD_W-1:0]   held_count;
    logic                dropped;
  } rm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_LOAD
  } rm_state_e;

endpackage

// ----- src/rm_stream_if.sv -----
// ----------------------------------------------------------------------------
// rm_stream_if: valid/ready stream channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface rm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rm_cell.sv -----
// ----------------------------------------------------------------------------
// rm_cell: one slot of the sorted insertion chain
// Holds one value, shifts up on insertion and forwards median taps downward.
// ----------------------------------------------------------------------------
module rm_cell import rm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
  parameter int CNT_W      = 11,
  parameter int IDX_W      = 10,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  ins_en_i,
  input  logic [VALUE_BITS-1:0] ins_val_i,
  input  logic [CNT_W-1:0]      fill_i,
  input  logic [IDX_W-1:0]      lo_idx_i,
  input  logic [IDX_W-1:0]      hi_idx_i,
  input  logic [VALUE_BITS-1:0] prev_val_i,
  input  logic                  prev_gt_i,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  gt_o,
  input  logic [VALUE_BITS-1:0] rd_lo_i,
  input  logic [VALUE_BITS-1:0] rd_hi_i,
  output logic [VALUE_BITS-1:0] rd_lo_o,
  output logic [VALUE_BITS-1:0] rd_hi_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] rd_lo_q, rd_hi_q;
  logic                  occupied;
  logic                  wr_en;

  assign occupied = CNT_W'(IDX) < fill_i;
  assign gt_o     = occupied && (val_q > ins_val_i);
  // take the new value at its slot, shift the upper part up by one
  assign wr_en    = ins_en_i && (gt_o || (CNT_W'(IDX) == fill_i));
  assign val_d    = prev_gt_i ? prev_val_i : ins_val_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_q <= val_d;
    end
    rd_lo_q <= (IDX_W'(IDX) == lo_idx_i) ? val_q : rd_lo_i;
    rd_hi_q <= (IDX_W'(IDX) == hi_idx_i) ? val_q : rd_hi_i;
  end

  assign val_o   = val_q;
  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

// ----- src/rm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rm_ctrl: running median sequencer
// Tracks the fill count, waits for the median taps to reach the chain head
// and loads the output register.
// ----------------------------------------------------------------------------
module rm_ctrl import rm_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int CNT_W    = 11,
  parameter int IDX_W    = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             start_new_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             ins_en_o,
  output logic [CNT_W-1:0] fill_o,
  output logic [CNT_W-1:0] count_o,
  output logic             drop_o,
  output logic             load_o,
  output logic [IDX_W-1:0] lo_idx_o,
  output logic [IDX_W-1:0] hi_idx_o
);

  rm_state_e        state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] wait_q, wait_d;
  logic             drop_q, drop_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] fill_eff;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign fill_eff = start_new_i ? '0 : count_q;
  assign full     = fill_eff == CNT_W'(CAPACITY);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_WAIT;
      ST_WAIT: if (wait_q == '0) state_d = ST_LOAD;
      ST_LOAD: if (load_o) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_WAIT: ;
      ST_LOAD: load_o = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    wait_d  = wait_q;
    if (accept) begin
      count_d = full ? count_q : fill_eff + CNT_W'(1);
      drop_d  = full;
      // the upper median tap walks down one cell per cycle to reach the head
      wait_d  = IDX_W'(count_d >> 1);
    end else if (state_q == ST_WAIT && wait_q != '0) begin
      wait_d  = wait_q - IDX_W'(1);
    end
    if (load_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wait_q      <= wait_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign ins_en_o    = accept && !full;
  assign fill_o      = fill_eff;
  assign count_o     = count_q;
  assign drop_o      = drop_q;
  assign out_valid_o = out_valid_q;
  assign lo_idx_o    = IDX_W'((count_q - CNT_W'(1)) >> 1);
  assign hi_idx_o    = IDX_W'(count_q >> 1);

endmodule

// ----- src/running_median.sv -----
// ----------------------------------------------------------------------------
// running_median: streaming median over a sorted insertion chain
// Flow: a new sample is taken only in idle, after the previous result has been
//   loaded into the output register, which waits for the sink to be ready.
//   Between the two, the median taps walk one cell per cycle down the chain
//   to the head.
// Reset: clears the fill count and handshake state; cell contents are left
//   undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module running_median import rm_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEFAULT,
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rm_stream_if.sink    in_i,
  rm_stream_if.source  out_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic                  ins_en;
  logic [VALUE_BITS-1:0] ins_val;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      count;
  logic                  drop;
  logic                  load;
  logic [IDX_W-1:0]      lo_idx, hi_idx;
  logic [VALUE_BITS:0]   mid_sum;
  rm_in_t                in_data;
  rm_out_t               out_q;

  logic [VALUE_BITS-1:0] val   [CAPACITY];
  logic                  gt    [CAPACITY];
  logic [VALUE_BITS-1:0] rd_lo [CAPACITY+1];
  logic [VALUE_BITS-1:0] rd_hi [CAPACITY+1];

  assign in_data = in_i.data;
  assign ins_val = VALUE_BITS'(in_data.sample_value);

  rm_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .start_new_i (in_data.start_new),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .ins_en_o    (ins_en),
    .fill_o      (fill),
    .count_o     (count),
    .drop_o      (drop),
    .load_o      (load),
    .lo_idx_o    (lo_idx),
    .hi_idx_o    (hi_idx)
  );

  assign rd_lo[CAPACITY] = '0;
  assign rd_hi[CAPACITY] = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_val;
    logic                  prev_gt;
    if (k == 0) begin : g_head
      assign prev_val = ins_val;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val[k-1];
      assign prev_gt  = gt[k-1];
    end
    rm_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .IDX        (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ins_en_i   (ins_en),
      .ins_val_i  (ins_val),
      .fill_i     (fill),
      .lo_idx_i   (lo_idx),
      .hi_idx_i   (hi_idx),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .val_o      (val[k]),
      .gt_o       (gt[k]),
      .rd_lo_i    (rd_lo[k+1]),
      .rd_hi_i    (rd_hi[k+1]),
      .rd_lo_o    (rd_lo[k]),
      .rd_hi_o    (rd_hi[k])
    );
  end

  // floor of the mean; equal taps for an odd count
  assign mid_sum = {1'b0, rd_lo[0]} + {1'b0, rd_hi[0]};

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.median_value <= SAMPLE_W'(mid_sum[VALUE_BITS:1]);
      out_q.held_count   <= HELD_W'(count);
      out_q.dropped      <= drop;
    end
  end

  assign out_o.data = out_q;

endmodule

// ----- dv/running_median_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_tb: stream check of the running median block
// Feeds unsigned samples through the input channel and compares every result
// (median, held count, drop flag) against a sorted-set predictor kept in the
// bench. Covers field extremes, duplicates, head and tail inserts, restarts,
// a store filled to capacity with dropped samples, and random sets under
// shifting backpressure on both channels.
// ----------------------------------------------------------------------------
module running_median_tb;
  import rm_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEFAULT;
  localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
  localparam logic [SAMPLE_W-1:0] VALUE_MASK = SAMPLE_W'((64'd1 << VALUE_BITS) - 1);

  logic clk_i;
  logic rst_ni;

  rm_stream_if #(.T(rm_in_t))  in_if ();
  rm_stream_if #(.T(rm_out_t)) out_if ();

  running_median #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: held samples in ascending order, results still owed.
  logic [SAMPLE_W-1:0] held_sorted[$];
  rm_out_t             owed_results[$];
  int                  err_count = 0;
  int                  source_idle_pct = 0;
  int                  sink_idle_pct = 0;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Insert after any equal entries, or flag a drop when the set is full.
  function automatic rm_out_t predict_median(input rm_in_t item);
    rm_out_t             res;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W:0]   pair_sum;
    int                  pos;
    int                  n;
    v = item.sample_value & VALUE_MASK;
    res.dropped = 1'b0;
    if (item.start_new) held_sorted.delete();
    if (held_sorted.size() < CAPACITY) begin
      pos = held_sorted.size();
      while (pos > 0 && held_sorted[pos-1] > v) pos--;
      held_sorted.insert(pos, v);
    end else begin
      res.dropped = 1'b1;
    end
    n = held_sorted.size();
    if (n % 2 == 1) begin
      res.median_value = held_sorted[(n-1)/2];
    end else begin
      pair_sum = {1'b0, held_sorted[n/2-1]} + {1'b0, held_sorted[n/2]};
      res.median_value = pair_sum[SAMPLE_W:1];
    end
    res.held_count = HELD_W'(n);
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom_range(15));
      4:       return {SAMPLE_W{1'b1}} - SAMPLE_W'($urandom_range(15));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic set_idling(input int src_pct, input int snk_pct);
    source_idle_pct = src_pct;
    sink_idle_pct   = snk_pct;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
    rm_in_t item;
    item.sample_value = value;
    item.start_new    = restart;
    while ($urandom_range(99) < source_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
    owed_results.push_back(predict_median(item));
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    rm_out_t want;
    rm_out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result median=%0h count=%0d",
                                  got.median_value, got.held_count));
      end else begin
        want = owed_results.pop_front();
        if (got.median_value !== want.median_value)
          report_mismatch($sformatf("median_value got %0h want %0h",
                                    got.median_value, want.median_value));
        if (got.held_count !== want.held_count)
          report_mismatch($sformatf("held_count got %0d want %0d",
                                    got.held_count, want.held_count));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped got %0b want %0b",
                                    got.dropped, want.dropped));
      end
    end
  end

  task automatic test_directed();
    // first sample after reset goes into an empty set without a restart
    push_sample(20'd5, 1'b0);
    push_sample(20'd0, 1'b0);
    push_sample(20'hFFFFF, 1'b0);
    push_sample(20'hFFFFF, 1'b0);
    // two top values: the pair sum needs the carry bit
    push_sample(20'hFFFFF, 1'b1);
    push_sample(20'hFFFFF, 1'b0);
    // alternating bit patterns with duplicates
    push_sample(20'hAAAAA, 1'b1);
    push_sample(20'h55555, 1'b0);
    push_sample(20'hAAAAA, 1'b0);
    push_sample(20'h55555, 1'b0);
    // descending values land at the head of the chain
    push_sample(20'd100, 1'b1);
    push_sample(20'd90, 1'b0);
    push_sample(20'd80, 1'b0);
    push_sample(20'd70, 1'b0);
    push_sample(20'd60, 1'b0);
    // ascending values land at the tail
    push_sample(20'd1, 1'b1);
    push_sample(20'd2, 1'b0);
    push_sample(20'd3, 1'b0);
    push_sample(20'd4, 1'b0);
    push_sample(20'd0, 1'b1);
    push_sample(20'd0, 1'b0);
  endtask

  task automatic test_store_full();
    int k;
    push_sample(pick_value(), 1'b1);
    for (k = 1; k < CAPACITY; k++) push_sample(pick_value(), 1'b0);
    // set is full: these are dropped and the median repeats
    push_sample('0, 1'b0);
    push_sample('1, 1'b0);
    push_sample(pick_value(), 1'b0);
    // a restart at full empties the set first, so the value is kept
    push_sample(pick_value(), 1'b1);
    push_sample(pick_value(), 1'b0);
  endtask

  task automatic test_random_sets(input int n_items);
    int sent;
    int set_len;
    int k;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (k = 0; k < set_len && sent < n_items; k++) begin
        // a stray restart now and then cuts a set short
        push_sample(pick_value(), (k == 0) || ($urandom_range(24) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(7, 67);
    test_directed();
    test_store_full();
    test_random_sets(185);
    set_idling(67, 7);
    test_random_sets(185);
    set_idling(0, 0);
    test_random_sets(185);
    in_if.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY / 2 + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
